// ===== sv/sorted_table_binary_insert_core_assert.svh =====
// ---------------------------------------------------------------------------
// Sorted table assertion macros
// Concurrent check macros shared by the sorted table core.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_INSERT_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_INSERT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define STBI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted table check failed");
`define STBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted table check failed");
`else
`define STBI_ASSERT_IMPLY(lbl, ante, cons)
`define STBI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/stbi_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted table package
// Sizes, codes and the cell control type of the sorted table core.
// ---------------------------------------------------------------------------
package stbi_pkg;

  localparam int DEPTH      = 1024;
  localparam int WORD_BITS  = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int GROUPS     = 32;
  localparam int GROUP_SIZE = DEPTH / GROUPS;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [DEPTH-1:0][WORD_BITS-1:0] word_bus_t;

  typedef struct packed {
    logic capture;
    logic load_val;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/sorted_table_binary_insert_core.sv =====
// An insert passes through the compare capture state, the lower bound steps over the clamped
// limit, the shift state and the result state; a read passes the two-stage gather tree before
// the result state, and a dropped insert on a full table goes straight to the result state.
// Only one request is in work at a time: in_stall holds off new requests until the result is
// loaded into the output registers, and a stalled output holds the core in its result state.
// Reset clears the count, the control state and the result valid; entries are not cleared.
// ---------------------------------------------------------------------------
// Sorted table binary insert core
// A row of entry cells with a shared search unit and a read gather tree.
// ---------------------------------------------------------------------------
`include "sorted_table_binary_insert_core_assert.svh"

module sorted_table_binary_insert_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    action,
  input  logic signed [stbi_pkg::WORD_BITS-1:0]   value,
  input  logic [stbi_pkg::CNT_BITS-1:0]           search_limit,
  input  logic [stbi_pkg::IDX_BITS-1:0]           read_index,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [stbi_pkg::IDX_BITS-1:0]           position,
  output logic signed [stbi_pkg::WORD_BITS-1:0]   read_data,
  output logic [stbi_pkg::CNT_BITS-1:0]           entry_count,
  output logic [1:0]                              status
);

  localparam int CW = stbi_pkg::CNT_BITS;
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(stbi_pkg::DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RD1    = 3'd4;
  localparam logic [2:0] S_RD2    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]                         state;
  logic [2:0]                         state_next;
  logic [CW-1:0]                      count;
  logic                               item_action;
  stbi_pkg::word_t                    item_value;
  logic [CW-1:0]                      item_limit;
  logic [stbi_pkg::IDX_BITS-1:0]      item_index;
  logic                               item_full;
  logic                               accept;
  logic                               out_load;
  logic                               rd_ok;
  logic                               full_take;

  stbi_pkg::cell_ctrl_t [stbi_pkg::DEPTH-1:0] cell_ctrl;
  stbi_pkg::word_bus_t                        entry_bus;
  logic [stbi_pkg::DEPTH-1:0]                 lt_vec;
  logic [CW-1:0]                              srch_lo;
  logic                                       srch_done;
  logic [stbi_pkg::WORD_BITS-1:0]             gather_data;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_RESULT) && (!out_valid || !out_stall);
  assign rd_ok     = ({1'b0, item_index} < count);
  assign full_take = accept && (action == stbi_pkg::ACT_INSERT) && (count >= CNT_FULL);

  for (genvar i = 0; i < stbi_pkg::DEPTH; i++) begin : g_cell
    stbi_pkg::word_t prev_entry;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
    end else begin : g_rest
      assign prev_entry = entry_bus[i-1];
    end

    assign cell_ctrl[i].capture  = (state == S_CMP);
    assign cell_ctrl[i].load_val = (state == S_SHIFT) && (srch_lo == CW'(i));
    assign cell_ctrl[i].shift    = (state == S_SHIFT) && (srch_lo < CW'(i))
                                   && (CW'(i) <= count);

    stbi_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .value      (item_value),
      .prev_entry (prev_entry),
      .entry      (entry_bus[i]),
      .lt         (lt_vec[i])
    );
  end

  stbi_search u_search (
    .clk    (clk),
    .start  (state == S_CMP),
    .limit  (item_limit),
    .lt_vec (lt_vec),
    .lo     (srch_lo),
    .done   (srch_done)
  );

  stbi_gather u_gather (
    .clk     (clk),
    .entries (entry_bus),
    .index   (item_index),
    .data    (gather_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == stbi_pkg::ACT_READ) begin
            state_next = S_RD1;
          end else if (count >= CNT_FULL) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP:    state_next = S_SEARCH;
      S_SEARCH: begin
        if (srch_done) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT:  state_next = S_RESULT;
      S_RD1:    state_next = S_RD2;
      S_RD2:    state_next = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT) begin
        count <= count + CNT_ONE;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= action;
      item_value  <= value;
      item_limit  <= (search_limit > count) ? count : search_limit;
      item_index  <= read_index;
      item_full   <= (count >= CNT_FULL);
    end
    if (out_load) begin
      entry_count <= count;
      if (item_action == stbi_pkg::ACT_READ) begin
        position  <= item_index;
        read_data <= rd_ok ? gather_data : '0;
        status    <= rd_ok ? stbi_pkg::ST_OK : stbi_pkg::ST_RANGE;
      end else if (item_full) begin
        position  <= '0;
        read_data <= '0;
        status    <= stbi_pkg::ST_FULL;
      end else begin
        position  <= srch_lo[stbi_pkg::IDX_BITS-1:0];
        read_data <= '0;
        status    <= stbi_pkg::ST_OK;
      end
    end
  end

  `STBI_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CNT_FULL)
  `STBI_ASSERT_NEXT(a_shift_counts, state == S_SHIFT, count == $past(count) + CNT_ONE)
  `STBI_ASSERT_NEXT(a_full_skips, full_take, state == S_RESULT)
  `STBI_ASSERT_IMPLY(a_pos_in_range, state == S_SHIFT, srch_lo <= count)

endmodule

// ===== sv/stbi_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted table cell
// Holds one entry, compares it with the request value and takes either the
// new value or its lower neighbour's entry.
// ---------------------------------------------------------------------------
module stbi_cell (
  input  logic                  clk,
  input  stbi_pkg::cell_ctrl_t  ctrl,
  input  stbi_pkg::word_t       value,
  input  stbi_pkg::word_t       prev_entry,
  output stbi_pkg::word_t       entry,
  output logic                  lt
);

  always_ff @(posedge clk) begin
    if (ctrl.load_val) begin
      entry <= value;
    end else if (ctrl.shift) begin
      entry <= prev_entry;
    end
    if (ctrl.capture) begin
      lt <= (entry < value);
    end
  end

endmodule

// ===== sv/stbi_search.sv =====
// ---------------------------------------------------------------------------
// Sorted table search unit
// Lower bound search over the captured less-than bits, one step a cycle.
// ---------------------------------------------------------------------------
module stbi_search (
  input  logic                              clk,
  input  logic                              start,
  input  logic [stbi_pkg::CNT_BITS-1:0]     limit,
  input  logic [stbi_pkg::DEPTH-1:0]        lt_vec,
  output logic [stbi_pkg::CNT_BITS-1:0]     lo,
  output logic                              done
);

  logic [stbi_pkg::CNT_BITS-1:0] hi;
  logic [stbi_pkg::CNT_BITS:0]   mid_sum;
  logic [stbi_pkg::IDX_BITS-1:0] mid;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[stbi_pkg::IDX_BITS:1];
  assign done    = (lo >= hi);

  always_ff @(posedge clk) begin
    if (start) begin
      lo <= '0;
      hi <= limit;
    end else if (!done) begin
      if (lt_vec[mid]) begin
        lo <= stbi_pkg::CNT_BITS'(mid) + stbi_pkg::CNT_BITS'(1);
      end else begin
        hi <= stbi_pkg::CNT_BITS'(mid);
      end
    end
  end

endmodule

// ===== sv/stbi_gather.sv =====
// ---------------------------------------------------------------------------
// Sorted table read gather
// Two-stage registered OR tree that picks the entry at the read index.
// ---------------------------------------------------------------------------
module stbi_gather (
  input  logic                              clk,
  input  stbi_pkg::word_bus_t               entries,
  input  logic [stbi_pkg::IDX_BITS-1:0]     index,
  output logic [stbi_pkg::WORD_BITS-1:0]    data
);

  logic [stbi_pkg::GROUPS-1:0][stbi_pkg::WORD_BITS-1:0] group_next;
  logic [stbi_pkg::GROUPS-1:0][stbi_pkg::WORD_BITS-1:0] group_or;
  logic [stbi_pkg::WORD_BITS-1:0]                       data_next;

  always_comb begin
    for (int g = 0; g < stbi_pkg::GROUPS; g++) begin
      group_next[g] = '0;
      for (int k = 0; k < stbi_pkg::GROUP_SIZE; k++) begin
        if (index == stbi_pkg::IDX_BITS'(g * stbi_pkg::GROUP_SIZE + k)) begin
          group_next[g] = group_next[g] | entries[g * stbi_pkg::GROUP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    data_next = '0;
    for (int g = 0; g < stbi_pkg::GROUPS; g++) begin
      data_next = data_next | group_or[g];
    end
  end

  always_ff @(posedge clk) begin
    group_or <= group_next;
    data     <= data_next;
  end

endmodule
